FILE: hw/rtl/sdc_pkg.sv
// sdc_pkg: types, codes and sizes shared by the sample buffer cache
// depends on nothing; used by sample_dma_buffer_cache
`default_nettype none
package sdc_pkg;

	localparam int NumBuffersDef  = 64;
	localparam int BufferBytesDef = 512;
	localparam logic [3:0] FrameLagRst = 4'd1;

	// result status codes
	localparam logic [1:0] ST_HIT   = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_FALLB = 2'd2;
	localparam logic [1:0] ST_FRAME = 2'd3;

	// request function codes
	localparam logic FN_SAMPLE = 1'b0;
	localparam logic FN_TICK   = 1'b1;

	typedef struct packed {
		logic        func;
		logic [30:0] rom_addr;
		logic [15:0] req_len;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  buf_index;
		logic [9:0]  buf_offset;
		logic [30:0] dma_rom_addr;
		logic [6:0]  freed_count;
	} out_item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sdc_ram.sv
// sdc_ram: generic single write port ram with one registered read port
// depends on nothing
`default_nettype none
module sdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/sample_dma_buffer_cache.sv
// sample_dma_buffer_cache: sorted buffer list cache in front of a rom dma
// depends on sdc_pkg and sdc_ram
// a request walks the in-use list one buffer at a time, passing over up to NUM_BUFFERS
//   buffers; on a miss busy stays high through S_MISS after the walk; a frame tick walks
//   every in-use buffer
// throughput: one item at a time, busy high while the list walk runs one node a cycle
// result strobe done lasts one cycle; the receiver cannot stall
// reset: lists, frame counter and frame lag reset at once, ram contents need no clearing
`default_nettype none
module sample_dma_buffer_cache #(
	parameter int NUM_BUFFERS  = sdc_pkg::NumBuffersDef,
	parameter int BUFFER_BYTES = sdc_pkg::BufferBytesDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire sdc_pkg::in_item_t req,
	output logic                   done,
	output sdc_pkg::out_item_t     rsp,
	input  wire logic              cfg_wr_en,
	input  wire logic [3:0]        cfg_wr_data
);
	import sdc_pkg::*;

	localparam int IDX_W = $clog2(NUM_BUFFERS);
	localparam int PTR_W = $clog2(NUM_BUFFERS + 1);
	localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_BUFFERS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_REQ  = 2'd1;
	localparam logic [1:0] S_TICK = 2'd2;
	localparam logic [1:0] S_MISS = 2'd3;

	logic [1:0]       st_q, st_d;
	logic [PTR_W-1:0] cur_q, cur_d, prev_q, prev_d, last_next_q, last_next_d;
	logic [PTR_W-1:0] steps_q, steps_d, freed_q, freed_d;
	logic [PTR_W-1:0] used_head_q, used_head_d, free_head_q, free_head_d;
	logic [PTR_W-1:0] fh_next_q, fh_next_d;
	logic [31:0]      frame_q, frame_d;
	logic [3:0]       lag_q;
	in_item_t         req_q;
	out_item_t        rsp_q, rsp_d;
	logic             done_q, done_d;

	// ram ports
	logic [30:0]      sa_rd;
	logic [31:0]      lf_rd;
	logic [PTR_W-1:0] un_rd, fn_raw, fn_rd;
	logic [IDX_W-1:0] node_raddr, fn_raddr_q;
	logic             sa_we, lf_we, un_we, fn_we;
	logic [IDX_W-1:0] sa_waddr, lf_waddr, un_waddr, fn_waddr;
	logic [30:0]      sa_wdata;
	logic [31:0]      lf_wdata;
	logic [PTR_W-1:0] un_wdata, fn_wdata;
	logic [NUM_BUFFERS-1:0] fn_vld_q;

	// shared walk compare values
	logic             cur_ok, beyond, fits, stale;
	logic [31:0]      sa32, addr32, addr_end;

	assign node_raddr = (st_q == S_IDLE) ? used_head_q[IDX_W-1:0] : un_rd[IDX_W-1:0];

	sdc_ram #(.WIDTH(31), .DEPTH(NUM_BUFFERS)) u_start (
		.clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(sa_wdata),
		.raddr(node_raddr), .rdata(sa_rd)
	);
	sdc_ram #(.WIDTH(32), .DEPTH(NUM_BUFFERS)) u_frame (
		.clk(clk), .we(lf_we), .waddr(lf_waddr), .wdata(lf_wdata),
		.raddr(node_raddr), .rdata(lf_rd)
	);
	sdc_ram #(.WIDTH(PTR_W), .DEPTH(NUM_BUFFERS)) u_used (
		.clk(clk), .we(un_we), .waddr(un_waddr), .wdata(un_wdata),
		.raddr(node_raddr), .rdata(un_rd)
	);
	sdc_ram #(.WIDTH(PTR_W), .DEPTH(NUM_BUFFERS)) u_free (
		.clk(clk), .we(fn_we), .waddr(fn_waddr), .wdata(fn_wdata),
		.raddr(fh_next_q[IDX_W-1:0]), .rdata(fn_raw)
	);

	// unwritten free link entries read as their reset chain value
	assign fn_rd = fn_vld_q[fn_raddr_q] ? fn_raw : (PTR_W'(fn_raddr_q) + PTR_W'(1));

	assign sa32     = {1'b0, sa_rd};
	assign addr32   = {1'b0, req_q.rom_addr};
	assign addr_end = addr32 + {16'd0, req_q.req_len};
	assign cur_ok   = (cur_q < NIL) && (steps_q < NIL);
	assign beyond   = sa32 > addr32;
	assign fits     = addr_end <= (sa32 + 32'(BUFFER_BYTES));
	assign stale    = (lf_rd + {28'd0, lag_q}) < frame_q;

	// sequencer
	always_comb begin
		st_d        = st_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		last_next_d = last_next_q;
		steps_d     = steps_q;
		freed_d     = freed_q;
		used_head_d = used_head_q;
		free_head_d = free_head_q;
		fh_next_d   = fh_next_q;
		frame_d     = frame_q;
		rsp_d       = rsp_q;
		done_d      = 1'b0;
		sa_we = 1'b0; sa_waddr = free_head_q[IDX_W-1:0];
		sa_wdata = {req_q.rom_addr[30:1], 1'b0};
		lf_we = 1'b0; lf_waddr = cur_q[IDX_W-1:0]; lf_wdata = frame_q;
		un_we = 1'b0; un_waddr = free_head_q[IDX_W-1:0]; un_wdata = NIL;
		fn_we = 1'b0; fn_waddr = cur_q[IDX_W-1:0]; fn_wdata = fh_next_q;
		unique case (st_q)
			S_IDLE: begin
				if (start) begin
					cur_d   = used_head_q;
					prev_d  = NIL;
					steps_d = '0;
					freed_d = '0;
					st_d    = (req.func == FN_TICK) ? S_TICK : S_REQ;
				end
			end
			S_REQ: begin
				if (cur_ok && !beyond && fits) begin
					// hit: stamp and answer
					lf_we    = 1'b1;
					rsp_d    = '{ST_HIT, 6'(cur_q), 10'(addr32 - sa32), 31'd0, 7'd0};
					done_d   = 1'b1;
					st_d     = S_IDLE;
				end else if (cur_ok && !beyond) begin
					prev_d      = cur_q;
					last_next_d = un_rd;
					cur_d       = un_rd;
					steps_d     = steps_q + PTR_W'(1);
				end else if (free_head_q < NIL) begin
					// miss: link new buffer ahead of the successor
					un_we    = 1'b1;
					un_wdata = (prev_q < NIL) ? last_next_q : used_head_q;
					sa_we    = 1'b1;
					lf_we    = 1'b1;
					lf_waddr = free_head_q[IDX_W-1:0];
					rsp_d    = '{ST_MISS, 6'(free_head_q), {9'd0, req_q.rom_addr[0]},
						{req_q.rom_addr[30:1], 1'b0}, 7'd0};
					done_d   = 1'b1;
					st_d     = S_MISS;
				end else begin
					// no free buffer fallback
					rsp_d  = '{ST_FALLB,
						(prev_q < NIL) ? 6'(prev_q) : ((used_head_q < NIL) ? 6'(used_head_q) : 6'd0),
						{9'd0, req_q.rom_addr[0]}, 31'd0, 7'd0};
					done_d = 1'b1;
					st_d   = S_IDLE;
				end
			end
			S_MISS: begin
				// finish the insert and pop the free list
				if (prev_q < NIL) begin
					un_we    = 1'b1;
					un_waddr = prev_q[IDX_W-1:0];
					un_wdata = free_head_q;
				end else begin
					used_head_d = free_head_q;
				end
				free_head_d = fh_next_q;
				fh_next_d   = fn_rd;
				st_d        = S_IDLE;
			end
			S_TICK: begin
				if (cur_ok) begin
					if (stale) begin
						// unlink from in-use list
						if (prev_q < NIL) begin
							un_we    = 1'b1;
							un_waddr = prev_q[IDX_W-1:0];
							un_wdata = un_rd;
						end else begin
							used_head_d = un_rd;
						end
						// put in second place on the free list, or at its head when it is empty
						if (free_head_q < NIL) begin
							fn_we     = 1'b1;
							fh_next_d = cur_q;
						end else begin
							free_head_d = cur_q;
							fh_next_d   = NIL;
						end
						freed_d = freed_q + PTR_W'(1);
					end else begin
						prev_d = cur_q;
					end
					cur_d   = un_rd;
					steps_d = steps_q + PTR_W'(1);
				end else begin
					frame_d = frame_q + 32'd1;
					rsp_d   = '{ST_FRAME, 6'd0, 10'd0, 31'd0, 7'(freed_q)};
					done_d  = 1'b1;
					st_d    = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			used_head_q <= NIL;
			free_head_q <= '0;
			fh_next_q   <= PTR_W'(1);
			frame_q     <= '0;
			lag_q       <= FrameLagRst;
			done_q      <= 1'b0;
			fn_vld_q    <= '0;
		end else begin
			st_q        <= st_d;
			used_head_q <= used_head_d;
			free_head_q <= free_head_d;
			fh_next_q   <= fh_next_d;
			frame_q     <= frame_d;
			done_q      <= done_d;
			if (cfg_wr_en) begin
				lag_q <= cfg_wr_data;
			end
			if (fn_we) begin
				fn_vld_q[fn_waddr] <= 1'b1;
			end
		end
	end

	// walk and payload registers
	always_ff @(posedge clk) begin
		cur_q       <= cur_d;
		prev_q      <= prev_d;
		last_next_q <= last_next_d;
		steps_q     <= steps_d;
		freed_q     <= freed_d;
		rsp_q       <= rsp_d;
		fn_raddr_q  <= fh_next_q[IDX_W-1:0];
		if (st_q == S_IDLE && start) begin
			req_q <= req;
		end
	end

	assign busy = (st_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// checks
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without work");
	a_miss_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_MISS) |-> (free_head_q < NIL)) else $error("miss without free buffer");
	a_free_link: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q < NIL) |-> (fh_next_q != free_head_q)) else $error("free list loops");
	a_freed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (freed_q <= steps_q || st_q != S_TICK)) else $error("freed count too high");
endmodule
`default_nettype wire

FILE: verif/tb_sample_dma_buffer_cache.sv
// tb_sample_dma_buffer_cache: self-checking bench for the sample buffer cache
// depends on sdc_pkg and sample_dma_buffer_cache; a local list model predicts each result
`timescale 1ns / 1ps
`default_nettype none
module tb_sample_dma_buffer_cache;
	import sdc_pkg::*;

	localparam int NB = 64;
	localparam int NIL = NB;
	localparam int DrainCycles = 200;
	localparam int CycleLimit = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	in_item_t req = '0;
	out_item_t rsp;
	logic cfg_wr_en = 1'b0;
	logic [3:0] cfg_wr_data = '0;

	sample_dma_buffer_cache u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cache model state
	logic [30:0] m_start[NB];
	logic [31:0] m_stamp[NB];
	int m_used_next[NB];
	int m_free_next[NB];
	int m_used_head, m_free_head;
	logic [31:0] m_frame;
	logic [3:0] m_lag;

	in_item_t pending_items[$];
	out_item_t expected_rsp[$];
	int errors = 0;
	int n_rsp = 0;
	int n_hit = 0, n_miss = 0, n_fallb = 0, n_tick = 0;
	longint cycles = 0;
	bit drv_active = 1'b1;
	logic [3:0] lags[5] = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd7};

	task automatic model_reset();
		for (int i = 0; i < NB; i++) begin
			m_start[i] = '0;
			m_stamp[i] = '0;
			m_used_next[i] = NIL;
			m_free_next[i] = i + 1;
		end
		m_used_head = NIL;
		m_free_head = 0;
		m_frame = '0;
		m_lag = FrameLagRst;
	endtask

	// predict one result from one accepted item
	function automatic out_item_t cache_predict(in_item_t it);
		out_item_t r;
		int cur, prv, nxt, last, steps, nb, freed;
		logic [31:0] a_end, a32;
		r = '0;
		if (it.func == FN_TICK) begin
			cur = m_used_head;
			prv = NIL;
			freed = 0;
			steps = 0;
			while (cur < NB && steps < NB) begin
				nxt = m_used_next[cur];
				steps++;
				if (m_stamp[cur] + 32'(m_lag) < m_frame) begin
					if (prv < NB) m_used_next[prv] = nxt;
					else m_used_head = nxt;
					if (m_free_head < NB) begin
						m_free_next[cur] = m_free_next[m_free_head];
						m_free_next[m_free_head] = cur;
					end else begin
						m_free_head = cur;
						m_free_next[cur] = NIL;
					end
					m_used_next[cur] = NIL;
					freed++;
				end else begin
					prv = cur;
				end
				cur = nxt;
			end
			m_frame = m_frame + 1;
			r.status = ST_FRAME;
			r.freed_count = 7'(freed);
			return r;
		end
		a32 = {1'b0, it.rom_addr};
		a_end = a32 + {16'd0, it.req_len};
		cur = m_used_head;
		last = NIL;
		steps = 0;
		while (cur < NB && steps < NB) begin
			steps++;
			if ({1'b0, m_start[cur]} > a32) break;
			if (a_end <= {1'b0, m_start[cur]} + 32'd512) begin
				m_stamp[cur] = m_frame;
				r.status = ST_HIT;
				r.buf_index = 6'(cur);
				r.buf_offset = 10'(a32 - {1'b0, m_start[cur]});
				return r;
			end
			last = cur;
			cur = m_used_next[cur];
		end
		nb = m_free_head;
		r.buf_offset = 10'(it.rom_addr[0]);
		if (nb >= NB) begin
			if (last >= NB) last = m_used_head;
			if (last >= NB) last = 0;
			r.status = ST_FALLB;
			r.buf_index = 6'(last);
			return r;
		end
		m_free_head = m_free_next[nb];
		m_free_next[nb] = NIL;
		if (last < NB) begin
			m_used_next[nb] = m_used_next[last];
			m_used_next[last] = nb;
		end else begin
			m_used_next[nb] = m_used_head;
			m_used_head = nb;
		end
		m_start[nb] = {it.rom_addr[30:1], 1'b0};
		m_stamp[nb] = m_frame;
		r.status = ST_MISS;
		r.buf_index = 6'(nb);
		r.dma_rom_addr = {it.rom_addr[30:1], 1'b0};
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		if (errors <= 40)
			$display("mismatch rsp %0d %s: got %0h want %0h", n_rsp, what, got, want);
	endtask

	// accept tracking at rising edges
	logic took = 1'b0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		took <= arst_n && start && !busy;
		if (arst_n && start && !busy) begin
			expected_rsp.push_back(cache_predict(req));
		end
	end

	// driver: one item from the queue per handshake, random gap between items
	int gap = 0;
	always @(negedge clk) begin
		if (arst_n && drv_active) begin
			if (start && !took) begin
				// item not taken yet, keep holding
			end else if (gap > 0) begin
				start <= 1'b0;
				gap <= gap - 1;
			end else if (pending_items.size() > 0) begin
				req <= pending_items.pop_front();
				start <= 1'b1;
				gap <= $urandom_range(0, 9);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("unexpected", rsp, 0);
			end else begin
				w = expected_rsp.pop_front();
				if (rsp.status != w.status) report_mismatch("status", rsp.status, w.status);
				if (rsp.buf_index != w.buf_index)
					report_mismatch("buf_index", rsp.buf_index, w.buf_index);
				if (rsp.buf_offset != w.buf_offset)
					report_mismatch("buf_offset", rsp.buf_offset, w.buf_offset);
				if (rsp.dma_rom_addr != w.dma_rom_addr)
					report_mismatch("dma_rom_addr", rsp.dma_rom_addr, w.dma_rom_addr);
				if (rsp.freed_count != w.freed_count)
					report_mismatch("freed_count", rsp.freed_count, w.freed_count);
				case (w.status)
					ST_HIT: n_hit++;
					ST_MISS: n_miss++;
					ST_FALLB: n_fallb++;
					default: n_tick++;
				endcase
			end
			n_rsp++;
		end
	end

	// timeout
	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic in_item_t mk(logic f, logic [30:0] a, logic [15:0] l);
		in_item_t it;
		it.func = f;
		it.rom_addr = a;
		it.req_len = l;
		return it;
	endfunction

	// wait until the cache has drained every expected item
	task automatic wait_idle();
		while (pending_items.size() > 0 || start || expected_rsp.size() > 0 || busy)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_lag(logic [3:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		m_lag = v;
	endtask

	// random phase: streams near a moving base, with ticks and noise
	task automatic random_phase(int n, logic [30:0] base, int tick_pct);
		logic [30:0] a;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < tick_pct) begin
				pending_items.push_back(mk(FN_TICK, 31'($urandom), 16'($urandom)));
			end else if (r < 90) begin
				a = base + 31'($urandom_range(0, 40000));
				pending_items.push_back(mk(FN_SAMPLE, a, 16'($urandom_range(0, 600))));
			end else begin
				pending_items.push_back(mk(FN_SAMPLE, 31'($urandom), 16'($urandom)));
			end
		end
	endtask

	initial begin
		model_reset();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: hits, misses, offset 512, odd address, extremes, ticks
		pending_items.push_back(mk(FN_SAMPLE, 31'h101, 16'd10));
		pending_items.push_back(mk(FN_SAMPLE, 31'h101, 16'd10));
		pending_items.push_back(mk(FN_SAMPLE, 31'h300, 16'd0));
		pending_items.push_back(mk(FN_SAMPLE, 31'h100, 16'd512));
		pending_items.push_back(mk(FN_SAMPLE, 31'h0, 16'hFFFF));
		pending_items.push_back(mk(FN_SAMPLE, 31'h7FFFFFFF, 16'hFFFF));
		pending_items.push_back(mk(FN_SAMPLE, 31'h7FFFFFFE, 16'd0));
		pending_items.push_back(mk(FN_SAMPLE, 31'h0, 16'd0));
		pending_items.push_back(mk(FN_TICK, 31'h7FFFFFFF, 16'hFFFF));
		pending_items.push_back(mk(FN_TICK, 31'h0, 16'h0));
		pending_items.push_back(mk(FN_TICK, 31'h0, 16'h0));
		pending_items.push_back(mk(FN_TICK, 31'h0, 16'h0));
		pending_items.push_back(mk(FN_SAMPLE, 31'h101, 16'd4));
		// fill the cache to reach no free buffer fallback
		for (int i = 0; i < 70; i++)
			pending_items.push_back(mk(FN_SAMPLE, 31'(32'h10000 + i * 2048 + 1), 16'd8));
		wait_idle();

		// random phases over lag settings, with a full drain between them
		for (int p = 0; p < 5; p++) begin
			write_lag(lags[p]);
			random_phase(240, 31'($urandom_range(0, 32'h7FFF0000)), 8 + p * 4);
			wait_idle();
		end
		drv_active = 1'b0;

		$display("responses %0d: hit %0d miss %0d fallback %0d frame %0d",
			n_rsp, n_hit, n_miss, n_fallb, n_tick);
		$display("frame lag swept over 0, 1, 3, 7, 15 with drained phases");
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
hw/rtl/sdc_pkg.sv
hw/rtl/sdc_ram.sv
hw/rtl/sample_dma_buffer_cache.sv
verif/tb_sample_dma_buffer_cache.sv
